/* sv/zohr_pkg.sv */
// Shared types, constants and control structures of the zero-order-hold resampler.
`default_nettype none

package zohr_pkg;

    localparam int TIME_W     = 64;
    localparam int VALUE_W    = 64;
    localparam int INTERVAL_W = 63;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;

    // Gap points emitted for one sample before the rest are skipped.
    localparam int MAX_FILL = 63;
    localparam int FILL_W   = $clog2(MAX_FILL + 1);

    // The remainder unit retires one dividend bit per cycle.
    localparam int DIV_STEPS = TIME_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_ENABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_TIME   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SNAP_MODE     = 2'd3;

    typedef struct packed {
        logic signed [TIME_W-1:0] sample_time;
        logic [VALUE_W-1:0]       sample_value;
    } in_word_t;

    typedef struct packed {
        logic signed [TIME_W-1:0] out_time;
        logic [VALUE_W-1:0]       out_value;
        logic                     last_of_run;
        logic                     points_skipped;
    } out_word_t;

    typedef struct packed {
        logic load;         // take the input word
        logic init_plain;   // first grid time is t plus interval
        logic init_anchor;  // first grid time is the anchor itself
        logic div_first;    // start remainder of (t - anchor)
        logic init_div;     // first grid time from the remainder
        logic emit_gap;     // produce (grid, held) and step the grid
        logic div_skip;     // start remainder for skipped gap points
        logic skip_div;     // advance the grid past the skipped points
        logic emit_hit;     // produce (t, v) on an exact grid hit
        logic finish;       // flush the last word and store the held value
    } ctrl_cmd_t;

    typedef struct packed {
        logic initialized;
        logic anchor_enable;
        logic snap_mode;
        logic t_lt_anchor;
        logic g_lt_t;
        logic g_eq_t;
        logic fill_max;
        logic pend_valid;
        logic out_free;
        logic div_done;
    } dp_sts_t;

endpackage

`default_nettype wire

/* sv/zohr_div.sv */
// Bit-serial remainder unit: unsigned 64-bit dividend modulo a 63-bit divisor.
`default_nettype none

module zohr_div (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              start,
    input  wire logic [zohr_pkg::TIME_W-1:0]       dividend,
    input  wire logic [zohr_pkg::INTERVAL_W-1:0]   divisor,
    output logic                                   done,
    output logic [zohr_pkg::INTERVAL_W-1:0]        remainder
);

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    logic [zohr_pkg::DIV_CNT_W-1:0]      cnt_reg, cnt_next;
    logic [zohr_pkg::TIME_W-1:0]         num_reg, num_next;
    logic [zohr_pkg::INTERVAL_W-1:0]     den_reg, den_next;
    logic [zohr_pkg::INTERVAL_W-1:0]     rem_reg, rem_next;
    logic [zohr_pkg::INTERVAL_W:0]       partial;

    always_comb begin
        partial   = {rem_reg, num_reg[zohr_pkg::TIME_W-1]};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = zohr_pkg::DIV_CNT_W'(zohr_pkg::DIV_STEPS - 1);
            num_next  = dividend;
            den_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            // The partial remainder stays below the divisor, so one subtract per bit.
            if (partial >= {1'b0, den_reg}) begin
                rem_next = zohr_pkg::INTERVAL_W'(partial - {1'b0, den_reg});
            end else begin
                rem_next = partial[zohr_pkg::INTERVAL_W-1:0];
            end
            num_next = {num_reg[zohr_pkg::TIME_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("remainder unit restarted while still working");
`endif

endmodule

`default_nettype wire

/* sv/zohr_dp.sv */
// Datapath: configuration, held value, grid time, pending word and output register.
`default_nettype none

module zohr_dp (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [zohr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [zohr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire zohr_pkg::in_word_t                s_data,
    input  wire zohr_pkg::ctrl_cmd_t               cmd,
    output zohr_pkg::dp_sts_t                      sts,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output zohr_pkg::out_word_t                    m_data
);

    logic [zohr_pkg::INTERVAL_W-1:0] interval_reg;
    logic                            anchor_en_reg;
    logic [zohr_pkg::TIME_W-1:0]     anchor_time_reg;
    logic                            snap_reg;
    logic                            initialized_reg;
    logic                            pend_valid_reg;
    logic                            m_valid_reg;

    logic [zohr_pkg::TIME_W-1:0]     t_reg;
    logic [zohr_pkg::VALUE_W-1:0]    v_reg;
    logic [zohr_pkg::VALUE_W-1:0]    held_reg, held_next;
    logic [zohr_pkg::TIME_W-1:0]     grid_reg, grid_next;
    logic [zohr_pkg::FILL_W-1:0]     fill_cnt_reg;
    logic                            skip_reg;
    logic                            neg_reg;
    logic [zohr_pkg::TIME_W-1:0]     pend_time_reg;
    logic [zohr_pkg::VALUE_W-1:0]    pend_value_reg;
    zohr_pkg::out_word_t             m_data_reg;

    logic [zohr_pkg::TIME_W-1:0]     dt_ext;
    logic [zohr_pkg::TIME_W-1:0]     rem_ext;
    logic [zohr_pkg::TIME_W-1:0]     t_minus_a;
    logic [zohr_pkg::TIME_W-1:0]     a_minus_t;
    logic [zohr_pkg::TIME_W-1:0]     div_dividend;
    logic                            div_start;
    logic                            div_done;
    logic [zohr_pkg::INTERVAL_W-1:0] div_rem;
    logic                            produce;
    logic                            out_load;
    logic                            out_free;

    assign dt_ext    = {1'b0, interval_reg};
    assign rem_ext   = {1'b0, div_rem};
    assign t_minus_a = t_reg - anchor_time_reg;
    assign a_minus_t = anchor_time_reg - t_reg;
    assign produce   = cmd.emit_gap | cmd.emit_hit;
    assign out_free  = !m_valid_reg || m_ready;
    assign out_load  = (produce | cmd.finish) & pend_valid_reg;

    // For the first grid time the magnitude of (t - anchor) is divided; for a
    // skip it is t - grid - 1, which is t plus the complement of the grid time.
    assign div_start    = cmd.div_first | cmd.div_skip;
    assign div_dividend = cmd.div_first ? (t_minus_a[zohr_pkg::TIME_W-1] ? a_minus_t : t_minus_a)
                                        : (t_reg + ~grid_reg);

    zohr_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (interval_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_comb begin
        grid_next = grid_reg;
        if (cmd.init_plain || cmd.emit_hit) begin
            grid_next = t_reg + dt_ext;
        end else if (cmd.init_anchor) begin
            grid_next = anchor_time_reg;
        end else if (cmd.init_div) begin
            // anchor + q * interval equals t minus the signed remainder.
            grid_next = (neg_reg ? (t_reg + rem_ext) : (t_reg - rem_ext))
                        + (snap_reg ? '0 : dt_ext);
        end else if (cmd.skip_div) begin
            grid_next = t_reg + dt_ext + ~rem_ext;
        end else if (cmd.emit_gap) begin
            grid_next = grid_reg + dt_ext;
        end
    end

    always_comb begin
        held_next = held_reg;
        if (cmd.load && initialized_reg && snap_reg) begin
            held_next = s_data.sample_value;
        end else if (cmd.init_plain || cmd.init_anchor || cmd.init_div || cmd.finish) begin
            held_next = v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg    <= zohr_pkg::INTERVAL_W'(1);
            anchor_en_reg   <= 1'b0;
            anchor_time_reg <= '0;
            snap_reg        <= 1'b0;
            initialized_reg <= 1'b0;
            pend_valid_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    zohr_pkg::REG_INTERVAL: begin
                        // A zero spacing behaves as a spacing of one.
                        if (cfg_wdata[zohr_pkg::INTERVAL_W-1:0] == '0) begin
                            interval_reg <= zohr_pkg::INTERVAL_W'(1);
                        end else begin
                            interval_reg <= cfg_wdata[zohr_pkg::INTERVAL_W-1:0];
                        end
                    end
                    zohr_pkg::REG_ANCHOR_ENABLE: anchor_en_reg   <= cfg_wdata[0];
                    zohr_pkg::REG_ANCHOR_TIME:   anchor_time_reg <= cfg_wdata;
                    zohr_pkg::REG_SNAP_MODE:     snap_reg        <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (cmd.init_plain || cmd.init_anchor || cmd.init_div) begin
                initialized_reg <= 1'b1;
            end
            if (produce) begin
                pend_valid_reg <= 1'b1;
            end else if (cmd.finish) begin
                pend_valid_reg <= 1'b0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        held_reg <= held_next;
        grid_reg <= grid_next;
        if (cmd.load) begin
            t_reg        <= s_data.sample_time;
            v_reg        <= s_data.sample_value;
            fill_cnt_reg <= '0;
            skip_reg     <= 1'b0;
        end else begin
            if (cmd.emit_gap) begin
                fill_cnt_reg <= fill_cnt_reg + 1'b1;
            end
            if (cmd.div_skip) begin
                skip_reg <= 1'b1;
            end
        end
        if (cmd.div_first) begin
            neg_reg <= t_minus_a[zohr_pkg::TIME_W-1];
        end
        if (produce) begin
            pend_time_reg  <= cmd.emit_hit ? t_reg : grid_reg;
            pend_value_reg <= cmd.emit_hit ? v_reg : held_reg;
        end
        // A pending word leaves as last only when the sample is finished.
        if (out_load) begin
            m_data_reg.out_time       <= pend_time_reg;
            m_data_reg.out_value      <= pend_value_reg;
            m_data_reg.last_of_run    <= cmd.finish;
            m_data_reg.points_skipped <= cmd.finish & skip_reg;
        end
    end

    always_comb begin
        sts.initialized   = initialized_reg;
        sts.anchor_enable = anchor_en_reg;
        sts.snap_mode     = snap_reg;
        sts.t_lt_anchor   = $signed(t_reg) < $signed(anchor_time_reg);
        sts.g_lt_t        = $signed(grid_reg) < $signed(t_reg);
        sts.g_eq_t        = grid_reg == t_reg;
        sts.fill_max      = fill_cnt_reg == zohr_pkg::FILL_W'(zohr_pkg::MAX_FILL);
        sts.pend_valid    = pend_valid_reg;
        sts.out_free      = out_free;
        sts.div_done      = div_done;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_ready))
        else $error("output word overwritten before it was taken");

    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> !pend_valid_reg)
        else $error("pending word left behind after the sample finished");

    a_fill_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_gap |-> (fill_cnt_reg != zohr_pkg::FILL_W'(zohr_pkg::MAX_FILL)))
        else $error("gap fill went beyond its limit");
`endif

endmodule

`default_nettype wire

/* sv/zohr_ctrl.sv */
// Controller: sequences first-grid setup, gap fill, grid hit and flush for each sample.
`default_nettype none

module zohr_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire zohr_pkg::dp_sts_t    sts,
    output zohr_pkg::ctrl_cmd_t       cmd
);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_INIT      = 3'd1;
    localparam logic [2:0] ST_DIV_FIRST = 3'd2;
    localparam logic [2:0] ST_GAP       = 3'd3;
    localparam logic [2:0] ST_DIV_SKIP  = 3'd4;
    localparam logic [2:0] ST_HIT       = 3'd5;
    localparam logic [2:0] ST_FINISH    = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       can_produce;

    // A new word may be made once any pending word has somewhere to go.
    assign can_produce = !sts.pend_valid || sts.out_free;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = sts.initialized ? ST_GAP : ST_INIT;
                end
            end
            ST_INIT: begin
                if (!sts.anchor_enable) begin
                    cmd.init_plain = 1'b1;
                    state_next     = sts.snap_mode ? ST_GAP : ST_FINISH;
                end else if (sts.t_lt_anchor) begin
                    cmd.init_anchor = 1'b1;
                    state_next      = sts.snap_mode ? ST_GAP : ST_FINISH;
                end else begin
                    cmd.div_first = 1'b1;
                    state_next    = ST_DIV_FIRST;
                end
            end
            ST_DIV_FIRST: begin
                if (sts.div_done) begin
                    cmd.init_div = 1'b1;
                    state_next   = sts.snap_mode ? ST_GAP : ST_FINISH;
                end
            end
            ST_GAP: begin
                if (sts.g_lt_t) begin
                    if (sts.fill_max) begin
                        cmd.div_skip = 1'b1;
                        state_next   = ST_DIV_SKIP;
                    end else if (can_produce) begin
                        cmd.emit_gap = 1'b1;
                    end
                end else begin
                    state_next = ST_HIT;
                end
            end
            ST_DIV_SKIP: begin
                if (sts.div_done) begin
                    cmd.skip_div = 1'b1;
                    state_next   = ST_HIT;
                end
            end
            ST_HIT: begin
                if (!sts.g_eq_t) begin
                    state_next = ST_FINISH;
                end else if (can_produce) begin
                    cmd.emit_hit = 1'b1;
                    state_next   = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (can_produce) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !sts.pend_valid)
        else $error("new word taken while a result of the last one is still pending");
`endif

endmodule

`default_nettype wire

/* sv/zero_order_hold_resampler.sv */
// Top level of the zero-order-hold resampler: controller and datapath.
`default_nettype none

// Takes timestamped words and re-emits them on a fixed time grid, each grid point
// carrying the value held at that time; the user must write configuration only while
// idle, which the block itself does not enforce. Words are handled one at a time and
// s_ready is high only between them. A word that causes no result passes accept, gap
// check, grid-hit check and finish; each gap result adds a step in the gap check,
// while a result on an exact grid hit adds none. The very first word passes accept,
// grid setup and finish when it only sets up the grid, or also the gap and grid-hit
// checks when snap mode lets it emit. The first word with the anchor enabled and at or
// after the anchor time, and any word whose gap exceeds 63 points, also need the
// bit-serial remainder unit, which retires one of 64 bits a cycle. A result waits in a
// holding register until it is known whether it is the last of its word, and then in
// the output register for m_ready; a back-pressured result channel stalls the sequence.
module zero_order_hold_resampler (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [zohr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [zohr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire zohr_pkg::in_word_t                s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output zohr_pkg::out_word_t                    m_data
);

    zohr_pkg::ctrl_cmd_t cmd;
    zohr_pkg::dp_sts_t   sts;

    zohr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    zohr_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

/* dv/zero_order_hold_resampler_test.sv */
// Self-checking testbench for the zero-order-hold resampler, with its own grid predictor.
`timescale 1ns / 1ps

module zero_order_hold_resampler_test;

    localparam logic signed [63:0] TIME_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] TIME_MIN = 64'sh8000_0000_0000_0000;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_CYCLES = 100;

    // Tracks the grid the block should follow and the points it owes.
    class hold_grid_tracker;
        logic [62:0]         interval      = 63'd1;
        logic                anchor_enable = 1'b0;
        logic signed [63:0]  anchor_time   = '0;
        logic                snap_mode     = 1'b0;
        logic [63:0]         held_value    = '0;
        logic signed [63:0]  next_grid     = '0;
        logic                initialized   = 1'b0;
        zohr_pkg::out_word_t pending_points[$];
        int                  bad_points    = 0;

        function void write_register(logic [zohr_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
            case (idx)
                zohr_pkg::REG_INTERVAL:      interval      = data[62:0];
                zohr_pkg::REG_ANCHOR_ENABLE: anchor_enable = data[0];
                zohr_pkg::REG_ANCHOR_TIME:   anchor_time   = data;
                zohr_pkg::REG_SNAP_MODE:     snap_mode     = data[0];
                default: ;
            endcase
        endfunction

        // A zero spacing behaves as a spacing of one.
        function logic [63:0] step_size();
            return (interval == '0) ? 64'd1 : {1'b0, interval};
        endfunction

        function void add_point(logic signed [63:0] at, logic [63:0] val);
            zohr_pkg::out_word_t p;
            p.out_time       = at;
            p.out_value      = val;
            p.last_of_run    = 1'b0;
            p.points_skipped = 1'b0;
            pending_points.push_back(p);
        endfunction

        function void note_sample(zohr_pkg::in_word_t w);
            logic signed [63:0]  t;
            logic [63:0]         v, dt, d, mag, q, k;
            zohr_pkg::out_word_t tail;
            int                  n;
            bit                  skipped;
            t = w.sample_time;
            v = w.sample_value;
            dt = step_size();
            n = 0;
            skipped = 1'b0;
            if (!initialized) begin
                if (!anchor_enable) begin
                    next_grid = t + dt;
                end else if (t < anchor_time) begin
                    next_grid = anchor_time;
                end else begin
                    // The difference may wrap negative; the quotient truncates towards zero.
                    d = t - anchor_time;
                    if (d[63]) begin
                        mag = -d;
                        q = -(mag / dt);
                    end else begin
                        q = d / dt;
                    end
                    if (!snap_mode) q = q + 64'd1;
                    next_grid = anchor_time + q * dt;
                end
                held_value = v;
                initialized = 1'b1;
                if (!snap_mode) return;
            end
            if (snap_mode) held_value = v;
            while (next_grid < t && !skipped) begin
                if (n >= zohr_pkg::MAX_FILL) begin
                    d = t - next_grid;
                    k = (d - 64'd1) / dt + 64'd1;
                    next_grid = next_grid + k * dt;
                    skipped = 1'b1;
                end else begin
                    add_point(next_grid, held_value);
                    n++;
                    next_grid = next_grid + dt;
                end
            end
            if (next_grid == t) begin
                add_point(t, v);
                n++;
                next_grid = t + dt;
            end
            held_value = v;
            if (n > 0) begin
                tail = pending_points.pop_back();
                tail.last_of_run    = 1'b1;
                tail.points_skipped = skipped;
                pending_points.push_back(tail);
            end
        endfunction

        function void check_result(zohr_pkg::out_word_t got);
            zohr_pkg::out_word_t want;
            if (pending_points.size() == 0) begin
                bad_points++;
                if (bad_points <= 10)
                    $display("unexpected word: time=%0d value=%h last=%b skipped=%b",
                             $signed(got.out_time), got.out_value, got.last_of_run,
                             got.points_skipped);
                return;
            end
            want = pending_points.pop_front();
            if (got.out_time !== want.out_time || got.out_value !== want.out_value ||
                got.last_of_run !== want.last_of_run ||
                got.points_skipped !== want.points_skipped) begin
                bad_points++;
                if (bad_points <= 10)
                    $display("wrong word: expected time=%0d value=%h last=%b skipped=%b,",
                             $signed(want.out_time), want.out_value, want.last_of_run,
                             want.points_skipped,
                             " got time=%0d value=%h last=%b skipped=%b",
                             $signed(got.out_time), got.out_value, got.last_of_run,
                             got.points_skipped);
            end
        endfunction
    endclass

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [zohr_pkg::CFG_IDX_W-1:0] cfg_index = zohr_pkg::REG_INTERVAL;
    logic [zohr_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    zohr_pkg::in_word_t             s_data    = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    zohr_pkg::out_word_t            m_data;

    hold_grid_tracker     book;
    logic signed [63:0]   last_time    = '0;
    bit                   send_idle_on = 1'b1;
    bit                   recv_idle_on = 1'b1;
    bit                   hold_pending = 1'b0;

    zero_order_hold_resampler dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return rand64();
        endcase
    endfunction

    // Leaves the write enable high; the caller lowers it after the last register.
    task automatic drive_register(input logic [zohr_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [63:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        book.write_register(idx, data);
    endtask

    task automatic set_config(input logic [63:0] step_word, input logic anchor_on,
                              input logic signed [63:0] anchor_at, input logic snap);
        drive_register(zohr_pkg::REG_INTERVAL, step_word);
        drive_register(zohr_pkg::REG_ANCHOR_ENABLE, {63'd0, anchor_on});
        drive_register(zohr_pkg::REG_ANCHOR_TIME, anchor_at);
        drive_register(zohr_pkg::REG_SNAP_MODE, {63'd0, snap});
        cfg_wr_en <= 1'b0;
    endtask

    // Valid is only lowered for a gap, so a back-to-back word never drops it.
    task automatic send_sample(input logic signed [63:0] t, input logic [63:0] v);
        int                 gap;
        zohr_pkg::in_word_t w;
        gap = send_idle_on ? int'($urandom_range(0, 5)) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        w.sample_time  = t;
        w.sample_value = v;
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        book.note_sample(w);
        last_time = t;
    endtask

    // Waits until every owed point has arrived and the block has gone quiet.
    task automatic settle();
        s_valid <= 1'b0;
        while (book.pending_points.size() != 0) @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    task automatic random_config();
        logic [63:0] step_word;
        case ($urandom_range(0, 3))
            0:       step_word = 64'($urandom_range(1, 4));
            1:       step_word = 64'($urandom_range(5, 1000));
            2:       step_word = rand64();
            default: step_word = $urandom_range(0, 1) ? 64'h7FFF_FFFF_FFFF_FFFF : 64'd0;
        endcase
        step_word[63] = 1'($urandom_range(0, 1));
        set_config(step_word, 1'($urandom_range(0, 1)), rand64(), 1'($urandom_range(0, 1)));
    endtask

    // Mostly words that walk forward along the grid, with some noise and jumps back.
    task automatic send_random_words(input int count);
        logic [63:0]        dt;
        logic signed [63:0] g, t;
        int                 pick;
        for (int i = 0; i < count; i++) begin
            dt = book.step_size();
            g  = book.next_grid;
            pick = int'($urandom_range(0, 99));
            if (pick < 40)
                t = last_time + rand64() % dt + ($urandom_range(0, 1) ? dt : 64'd0);
            else if (pick < 60)
                t = g + dt * 64'($urandom_range(0, 3));
            else if (pick < 75)
                t = g + dt * 64'($urandom_range(4, 70)) + rand64() % dt;
            else if (pick < 85)
                t = last_time - 64'($urandom_range(0, 50));
            else if (pick < 95)
                t = rand64();
            else
                t = $urandom_range(0, 1) ? TIME_MAX : TIME_MIN;
            send_sample(t, pick_value());
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready === 1'b1)
            book.check_result(m_data);
    end

    // Result side: random stalls, and a long hold-off when asked for.
    initial begin
        int gap;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = recv_idle_on ? int'($urandom_range(0, 5)) : 0;
            if (hold_pending) begin
                gap = HOLD_CYCLES;
                hold_pending = 1'b0;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (m_valid !== 1'b1) @(posedge aclk);
        end
    end

    initial begin
        #10_000_000;
        $display("zero_order_hold_resampler: mismatch");
        $finish;
    end

    initial begin
        logic [63:0]        dt;
        logic [62:0]        first_step;
        logic signed [63:0] first_time;
        int                 start_kind;
        book = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // The first word fixes the grid origin, and only one first word occurs per run.
        first_step = 63'($urandom_range(2, 16));
        start_kind = int'($urandom_range(0, 4));
        case (start_kind)
            0: begin
                set_config({1'b0, first_step}, 1'b0, rand64(), 1'b0);
                first_time = $signed(64'($urandom)) - 64'sd1000;
            end
            1: begin
                set_config({1'b0, first_step}, 1'b1, 64'sd1000, 1'($urandom_range(0, 1)));
                first_time = 64'sd500;
            end
            2: begin
                set_config({1'b0, first_step}, 1'b1, -64'sd37, 1'b1);
                first_time = 64'(1000 + $urandom_range(0, 40));
            end
            3: begin
                set_config({1'b0, first_step}, 1'b1, -64'sd37, 1'b0);
                first_time = 64'(1000 + $urandom_range(0, 40));
            end
            default: begin
                // The distance from the anchor wraps past the largest time.
                set_config({1'b0, first_step}, 1'b1, TIME_MIN, 1'($urandom_range(0, 1)));
                first_time = TIME_MAX - 64'($urandom_range(0, 1000));
            end
        endcase
        send_sample(first_time, rand64());

        dt = book.step_size();
        send_sample(book.next_grid, '1);
        send_sample(book.next_grid + 64'd3 * dt + 64'd1, '0);
        send_sample(last_time, rand64());
        send_sample(last_time - 64'sd7, rand64());
        send_sample(book.next_grid + 64'd63 * dt, rand64());
        send_sample(book.next_grid + 64'd64 * dt, rand64());
        send_sample(book.next_grid + 64'd100 * dt + 64'd1, rand64());
        send_random_words(45);
        settle();

        // Zero spacing, no idling on either side, and a grid that wraps round.
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        set_config(64'h8000_0000_0000_0000, 1'b0, TIME_MAX, 1'b1);
        send_sample(TIME_MAX, '1);
        send_sample(TIME_MIN, '0);
        send_sample(TIME_MIN + 64'sd5, rand64());
        send_random_words(40);
        settle();

        // Widest spacing: a step of the grid can wrap past the largest time.
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        set_config(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, TIME_MIN, 1'b0);
        send_sample(book.next_grid, rand64());
        send_sample(TIME_MAX, rand64());
        send_sample(TIME_MIN, rand64());
        send_random_words(40);
        settle();

        for (int ph = 0; ph < 4; ph++) begin
            random_config();
            send_idle_on = $urandom_range(0, 3) != 0;
            recv_idle_on = $urandom_range(0, 3) != 0;
            if (ph == 1) hold_pending = 1'b1;
            send_random_words(36);
            settle();
        end

        if (book.bad_points == 0 && book.pending_points.size() == 0)
            $display("zero_order_hold_resampler: match");
        else
            $display("zero_order_hold_resampler: mismatch");
        $finish;
    end

endmodule
